// ===== design/jac_pkg.sv =====
// jac_pkg: shared constants for the joystick axis conditioner
// register indexes of the configuration port and the root table of the power step
// no dependencies
package jac_pkg;

	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_RAW_MINIMUM    = 3'd0;
	localparam logic [IDX_W-1:0] REG_RAW_CENTER     = 3'd1;
	localparam logic [IDX_W-1:0] REG_RAW_MAXIMUM    = 3'd2;
	localparam logic [IDX_W-1:0] REG_DEAD_ZONE      = 3'd3;
	localparam logic [IDX_W-1:0] REG_CURVE_EXPONENT = 3'd4;
	localparam logic [IDX_W-1:0] REG_INVERT_AXIS    = 3'd5;

	localparam int CURVE_W = 11;
	localparam logic [CURVE_W-1:0] CURVE_UNITY = 11'd256;
	localparam logic [6:0] HUNDRED = 7'd100;

	// floor square root, elaboration only
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = v;
		r = '0;
		b = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (b > x) b = b >> 2;
		end
		for (int j = 0; j < 32; j++) begin
			if (b != 64'd0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// q30 value of 2^(-2^-(i+1))
	function automatic logic [29:0] root_const(input int i);
		logic [63:0] r;
		r = isqrt64(64'd1 << 59);
		for (int j = 0; j < 16; j++) begin
			if (j < i) r = isqrt64(r << 30);
		end
		return r[29:0];
	endfunction

	localparam logic [29:0] ROOT_TAB [16] = '{
		root_const(0),  root_const(1),  root_const(2),  root_const(3),
		root_const(4),  root_const(5),  root_const(6),  root_const(7),
		root_const(8),  root_const(9),  root_const(10), root_const(11),
		root_const(12), root_const(13), root_const(14), root_const(15)
	};

endpackage

// ===== design/joystick_axis_conditioner.sv =====
// joystick_axis_conditioner: raw adc sample to axis position in hundredths
// depends on jac_pkg (register indexes, root table)
// one shared 32x32 multiplier and a bit-serial divider under one sequencer
//
// Takes one raw stick sample per word on the s_ side and returns one word on the
// m_ side: the axis position in hundredths (-100..100) and a flag that is high
// when the position differs from the previous word. Samples strictly inside
// raw_center +/- dead_zone give 0; otherwise the distance past the dead zone edge
// is divided by the span to raw_maximum or raw_minimum, clamped to full scale,
// optionally bent by the curve m^(curve_exponent/256) when curve_exponent is
// above 256 (q3.8), rounded half away from zero and optionally inverted. An empty
// or negative span saturates to full scale unless the distance is zero. s_tready is
// high only while the sequencer is idle. A word without the curve goes through setup,
// the divider at one quotient bit per cycle (skipped for zero or full-scale cases)
// and the scaling product; with the curve come a normalising shift, sixteen
// squarings on the shared multiplier, the exponent product, the root products and
// a final shift. The result sits in an output register so the next sample is taken
// while it waits. Configuration writes are always accepted and must only be made
// while the block is idle.
module joystick_axis_conditioner #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// raw_sample from bit 0, zero filled to whole bytes
	input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// axis_hundredths (two's complement)
	output logic [7:0] m_tdata,
	// position_changed
	output logic m_tuser,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [((SAMPLE_BITS > 11) ? SAMPLE_BITS : 11) - 1:0] cfg_data
);
	import jac_pkg::*;

	// signed width that holds the dead zone edges and spans without wrapping
	localparam int W = SAMPLE_BITS + 2;
	localparam int ZW = SAMPLE_BITS - 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SETUP, ST_DIV, ST_CHECK, ST_NORM, ST_SQM, ST_SQA, ST_PM, ST_PA,
		ST_PWB, ST_PWM, ST_PWA, ST_SHIFT, ST_HM, ST_HA, ST_FIN
	} state_t;

	state_t state_q;

	// configuration registers
	logic [SAMPLE_BITS-1:0] raw_minimum_q;
	logic [SAMPLE_BITS-1:0] raw_center_q;
	logic [SAMPLE_BITS-1:0] raw_maximum_q;
	logic [ZW-1:0]          dead_zone_q;
	logic [CURVE_W-1:0]     curve_exponent_q;
	logic                   invert_axis_q;

	// datapath
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   neg_q;
	logic [W-1:0]           span_q;
	logic [W-1:0]           rem_q;
	logic [30:0]            mag_q;
	logic [30:0]            y_q;
	logic [4:0]             sh_q;
	logic [15:0]            frac_q;
	logic [23:0]            p_q;
	logic [30:0]            acc_q;
	logic [4:0]             cnt_q;
	logic [63:0]            prod_q;
	logic signed [7:0]      val_q;
	logic signed [7:0]      prev_q;
	logic [7:0]             out_data_q;
	logic                   out_chg_q;
	logic                   out_valid_q;

	// setup comparisons
	logic signed [W-1:0] s_ext, ct_ext, lo, hi, distance, span;
	logic                in_zone;

	always_comb begin
		s_ext  = signed'({2'b00, sample_q});
		ct_ext = signed'({2'b00, raw_center_q});
		lo     = ct_ext - signed'({3'b000, dead_zone_q});
		hi     = ct_ext + signed'({3'b000, dead_zone_q});
		in_zone = (s_ext > lo) && (s_ext < hi);
		distance = '0;
		span = '0;
		if (!in_zone) begin
			if (s_ext > ct_ext) begin
				distance = s_ext - hi;
				span = signed'({2'b00, raw_maximum_q}) - hi;
			end else begin
				distance = lo - s_ext;
				span = lo - signed'({2'b00, raw_minimum_q});
			end
		end
	end

	// restoring divider step
	logic [W:0] rem2;
	logic       qbit;
	assign rem2 = {rem_q, 1'b0};
	assign qbit = (rem2 >= {1'b0, span_q});

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [20:0] log_a;
	assign log_a = {sh_q, 16'd0} - {5'd0, frac_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQM: begin
				mul_a = {1'b0, y_q};
				mul_b = {1'b0, y_q};
			end
			ST_PM: begin
				mul_a = {11'd0, log_a};
				mul_b = {21'd0, curve_exponent_q};
			end
			ST_PWM: begin
				mul_a = {1'b0, acc_q};
				mul_b = {2'b00, ROOT_TAB[cnt_q[3:0]]};
			end
			ST_HM: begin
				mul_a = {1'b0, mag_q};
				mul_b = {25'd0, HUNDRED};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	logic [31:0] sq_top;
	logic [32:0] p_sum;
	logic [37:0] h_sum;
	logic [6:0]  h_mag;
	logic signed [7:0] h_signed, h_final;

	assign sq_top = prod_q[61:30];
	assign p_sum  = {1'b0, prod_q[31:0]} + 33'd128;
	assign h_sum  = prod_q[37:0] + (38'd1 << 29);
	assign h_mag  = h_sum[36:30];
	assign h_signed = neg_q ? -signed'({1'b0, h_mag}) : signed'({1'b0, h_mag});
	assign h_final  = invert_axis_q ? -h_signed : h_signed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_minimum_q    <= '0;
			raw_center_q     <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
			raw_maximum_q    <= '1;
			dead_zone_q      <= '0;
			curve_exponent_q <= CURVE_UNITY;
			invert_axis_q    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RAW_MINIMUM:    raw_minimum_q    <= cfg_data[SAMPLE_BITS-1:0];
				REG_RAW_CENTER:     raw_center_q     <= cfg_data[SAMPLE_BITS-1:0];
				REG_RAW_MAXIMUM:    raw_maximum_q    <= cfg_data[SAMPLE_BITS-1:0];
				REG_DEAD_ZONE:      dead_zone_q      <= cfg_data[ZW-1:0];
				REG_CURVE_EXPONENT: curve_exponent_q <= cfg_data[CURVE_W-1:0];
				REG_INVERT_AXIS:    invert_axis_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// the finishing state reloads the output register itself
			if (out_valid_q && m_tready && state_q != ST_FIN) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						sample_q <= s_tdata[SAMPLE_BITS-1:0];
						state_q  <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					neg_q  <= !in_zone && !(s_ext > ct_ext);
					span_q <= span;
					rem_q  <= distance;
					if (distance <= 0) begin
						mag_q   <= '0;
						state_q <= ST_CHECK;
					end else if (span <= 0 || distance >= span) begin
						mag_q   <= 31'd1 << 30;
						state_q <= ST_CHECK;
					end else begin
						mag_q   <= '0;
						cnt_q   <= 5'd29;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= qbit ? W'(rem2 - {1'b0, span_q}) : rem2[W-1:0];
					mag_q <= {mag_q[29:0], qbit};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					y_q  <= mag_q;
					sh_q <= '0;
					if (curve_exponent_q > CURVE_UNITY && mag_q != 31'd0 && !mag_q[30])
						state_q <= ST_NORM;
					else
						state_q <= ST_HM;
				end
				ST_NORM: begin
					if (y_q[30]) begin
						cnt_q   <= '0;
						frac_q  <= '0;
						state_q <= ST_SQM;
					end else begin
						y_q  <= {y_q[29:0], 1'b0};
						sh_q <= sh_q + 5'd1;
					end
				end
				ST_SQM: state_q <= ST_SQA;
				ST_SQA: begin
					y_q    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
					frac_q <= {frac_q[14:0], sq_top[31]};
					if (cnt_q == 5'd15) begin
						state_q <= ST_PM;
					end else begin
						cnt_q   <= cnt_q + 5'd1;
						state_q <= ST_SQM;
					end
				end
				ST_PM: state_q <= ST_PA;
				ST_PA: begin
					p_q     <= p_sum[31:8];
					acc_q   <= 31'd1 << 30;
					cnt_q   <= '0;
					state_q <= ST_PWB;
				end
				ST_PWB: begin
					if (p_q[4'd15 - cnt_q[3:0]]) begin
						state_q <= ST_PWM;
					end else if (cnt_q == 5'd15) begin
						state_q <= ST_SHIFT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_PWM: state_q <= ST_PWA;
				ST_PWA: begin
					acc_q <= prod_q[60:30];
					if (cnt_q == 5'd15) begin
						state_q <= ST_SHIFT;
					end else begin
						cnt_q   <= cnt_q + 5'd1;
						state_q <= ST_PWB;
					end
				end
				ST_SHIFT: begin
					mag_q   <= (p_q[23:16] >= 8'd31) ? 31'd0 : (acc_q >> p_q[20:16]);
					state_q <= ST_HM;
				end
				ST_HM: state_q <= ST_HA;
				ST_HA: begin
					val_q   <= h_final;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= val_q;
						out_chg_q   <= (val_q != prev_q);
						prev_q      <= val_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_chg_q;

endmodule

// ===== design/jac_checker.sv =====
// jac_port_checks: port-level checks for joystick_axis_conditioner
// bound to the top level below; no package needed
module jac_port_checks (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       cfg_ready
);

	// position stays within full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata) <= 8'sd100 && $signed(m_tdata) >= -8'sd100))
		else $error("axis word out of range");

	// a sample starts a multi-cycle computation
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while busy");

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result word changed under stall");

	// a new result word only appears as the sequencer finishes a sample
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("spurious result");

	assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

endmodule

bind joystick_axis_conditioner jac_port_checks u_jac_port_checks (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
	.cfg_ready(cfg_ready)
);

// ===== dv/jac_checker.sv =====
// jac_checker: watches the sample, result and configuration channels of the axis conditioner
// holds its own shadow of the registers and predicts every result word in order
// depends on jac_pkg (register indexes)
`timescale 1ns / 1ps
module jac_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data,
	output int          fail_count,
	output int          pending_words,
	output int          words_checked
);
	import jac_pkg::*;

	typedef struct packed {
		logic [7:0] axis;
		logic       changed;
	} axis_word_t;

	localparam longint unsigned UNITY_Q30 = 64'd1 << 30;

	logic [11:0] sh_min, sh_center, sh_max;
	logic [10:0] sh_zone, sh_curve;
	logic        sh_invert;
	int          last_axis;
	axis_word_t  axis_queue[$];
	longint unsigned half_powers[16];

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v) root = trial;
		end
		return root;
	endfunction

	initial begin
		half_powers[0] = floor_sqrt(64'd1 << 59);
		for (int i = 1; i < 16; i++) half_powers[i] = floor_sqrt(half_powers[i-1] << 30);
	end

	// m^(e/256) for 0 < m < 1.0 in q30, via a log2 / exp2 pair
	function automatic longint unsigned bend(longint unsigned m, longint unsigned e);
		int unsigned lead;
		longint unsigned y, log_frac, neg_log, prod, acc;
		lead = 0;
		while (lead < 30 && (m >> (lead + 1)) != 0) lead++;
		y = m << (30 - lead);
		log_frac = 0;
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 30;
			log_frac = log_frac << 1;
			if (y >= (UNITY_Q30 << 1)) begin
				y = y >> 1;
				log_frac = log_frac | 1;
			end
		end
		neg_log = (longint'(30 - lead) << 16) - log_frac;
		prod = (neg_log * e + 128) >> 8;
		acc = UNITY_Q30;
		for (int i = 0; i < 16; i++)
			if (prod[15-i]) acc = (acc * half_powers[i]) >> 30;
		if ((prod >> 16) >= 31) return 0;
		return acc >> (prod >> 16);
	endfunction

	function automatic axis_word_t condition_sample(logic [11:0] raw);
		int s, lo, hi, distance, span, val;
		bit neg;
		longint unsigned mag, hund;
		axis_word_t w;
		s = raw;
		lo = int'(sh_center) - int'(sh_zone);
		hi = int'(sh_center) + int'(sh_zone);
		distance = 0;
		span = 0;
		neg = 0;
		if (!(s > lo && s < hi)) begin
			if (s > int'(sh_center)) begin
				distance = s - hi;
				span = int'(sh_max) - hi;
			end else begin
				distance = lo - s;
				span = lo - int'(sh_min);
				neg = 1;
			end
		end
		if (distance <= 0) mag = 0;
		else if (span <= 0 || distance >= span) mag = UNITY_Q30;
		else mag = (longint'(distance) << 30) / longint'(span);
		if (sh_curve > CURVE_UNITY && mag > 0 && mag < UNITY_Q30) mag = bend(mag, sh_curve);
		hund = (mag * 100 + (UNITY_Q30 >> 1)) >> 30;
		val = neg ? -int'(hund) : int'(hund);
		if (sh_invert) val = -val;
		w.axis = val[7:0];
		w.changed = (val != last_axis);
		last_axis = val;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		axis_word_t want;
		if (!arst_n) begin
			sh_min = 12'd0;
			sh_center = 12'd2048;
			sh_max = 12'd4095;
			sh_zone = 11'd0;
			sh_curve = CURVE_UNITY;
			sh_invert = 1'b0;
			last_axis = 0;
			axis_queue.delete();
			fail_count = 0;
			words_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RAW_MINIMUM:    sh_min = cfg_data;
					REG_RAW_CENTER:     sh_center = cfg_data;
					REG_RAW_MAXIMUM:    sh_max = cfg_data;
					REG_DEAD_ZONE:      sh_zone = cfg_data[10:0];
					REG_CURVE_EXPONENT: sh_curve = cfg_data[10:0];
					REG_INVERT_AXIS:    sh_invert = cfg_data[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				words_checked++;
				if (axis_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word axis=%0d changed=%0b",
							$signed(m_tdata), m_tuser);
				end else begin
					want = axis_queue.pop_front();
					if (want.axis !== m_tdata || want.changed !== m_tuser) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected axis=%0d changed=%0b, got axis=%0d changed=%0b",
								$signed(want.axis), want.changed, $signed(m_tdata), m_tuser);
					end
				end
			end
			if (s_tvalid && s_tready) axis_queue.push_back(condition_sample(s_tdata[11:0]));
		end
		pending_words = axis_queue.size();
	end
endmodule

// ===== dv/joystick_axis_conditioner_tb.sv =====
// joystick_axis_conditioner_tb: stimulus and verdict for the axis conditioner
// drives samples and register writes with random gaps; jac_checker does the prediction
// depends on jac_pkg, jac_checker and joystick_axis_conditioner
`timescale 1ns / 1ps
module joystick_axis_conditioner_tb;
	import jac_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 200;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid, s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid, m_tready;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [11:0] cfg_data;

	int fail_count, pending_words, words_checked;
	int samples_sent;
	int phases_run;
	int cycle_count;
	bit hold_off_request;

	joystick_axis_conditioner dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	jac_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_words(pending_words), .words_checked(words_checked)
	);

	// free-running clock, 10 ns period
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on a plain cycle count
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("joystick_axis_conditioner_tb NOT OK");
				$finish;
			end
		end
	end

	// result side: random stall per word, plus one long hold-off on request
	initial begin
		int unsigned gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_request) begin
				m_tready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_off_request = 1'b0;
			end
			gap = $urandom_range(0, 7);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			// word leaves at the edge where valid was already high with ready
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// one sample word, after a random gap; valid stays up for a back-to-back word
	task automatic send_sample(input logic [11:0] raw);
		int unsigned gap;
		gap = $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {4'd0, raw};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		samples_sent++;
	endtask

	// valid stays up between writes; the caller drops it after the last one
	task automatic write_reg(input logic [2:0] idx, input logic [11:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// registers only change once every word has drained and the sequencer is quiet
	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		while (pending_words != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_setting(input logic [11:0] lo_cal, input logic [11:0] mid_cal,
			input logic [11:0] hi_cal, input logic [10:0] zone, input logic [10:0] curve,
			input logic inv);
		drain_and_settle();
		write_reg(REG_RAW_MINIMUM, lo_cal);
		write_reg(REG_RAW_CENTER, mid_cal);
		write_reg(REG_RAW_MAXIMUM, hi_cal);
		write_reg(REG_DEAD_ZONE, {1'b0, zone});
		write_reg(REG_CURVE_EXPONENT, {1'b0, curve});
		write_reg(REG_INVERT_AXIS, {11'd0, inv});
		cfg_valid <= 1'b0;
		phases_run++;
	endtask

	// samples aimed near the dead-zone edges and the calibration ends, rest anywhere
	function automatic logic [11:0] pick_sample(int mid, int zone, int lo_cal, int hi_cal);
		int v;
		case ($urandom_range(0, 3))
			0: v = mid + ($urandom_range(0, 1) ? zone : -zone) + $urandom_range(0, 6) - 3;
			1: v = ($urandom_range(0, 1) ? lo_cal : hi_cal) + $urandom_range(0, 6) - 3;
			default: v = $urandom_range(0, 4095);
		endcase
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return v[11:0];
	endfunction

	task automatic random_burst(input int count, input int mid, input int zone,
			input int lo_cal, input int hi_cal);
		for (int i = 0; i < count; i++) send_sample(pick_sample(mid, zone, lo_cal, hi_cal));
	endtask

	initial begin
		logic [11:0] r_min, r_mid, r_max;
		logic [10:0] r_zone, r_curve;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_RAW_MINIMUM;
		cfg_data = '0;
		samples_sent = 0;
		phases_run = 0;
		hold_off_request = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset calibration: ends, centre, edges, repeats (no change flag)
		send_sample(12'd0);
		send_sample(12'd4095);
		send_sample(12'd2048);
		send_sample(12'd2048);
		send_sample(12'd2049);
		send_sample(12'd2047);
		send_sample(12'd3071);
		send_sample(12'd1024);
		send_sample(12'hAAA);
		send_sample(12'h555);

		// dead zone and curve: inside the zone, exactly at its edges, curved midrange
		load_setting(12'd100, 12'd2000, 12'd3900, 11'd300, 11'd640, 1'b0);
		send_sample(12'd1701);
		send_sample(12'd2299);
		send_sample(12'd1700);
		send_sample(12'd2300);
		send_sample(12'd3100);
		send_sample(12'd900);
		send_sample(12'd3901);
		send_sample(12'd50);

		// empty span on both sides: zero distance still gives 0, else full scale
		load_setting(12'd2500, 12'd2048, 12'd1500, 11'd0, 11'd256, 1'b1);
		send_sample(12'd2048);
		send_sample(12'd2049);
		send_sample(12'd2047);
		send_sample(12'd4095);
		send_sample(12'd0);

		// extremes, zone edges beyond the sample range
		load_setting(12'd0, 12'd4095, 12'd4095, 11'd2047, 11'd2047, 1'b1);
		random_burst(40, 4095, 2047, 0, 4095);
		load_setting(12'd4095, 12'd0, 12'd0, 11'd2047, 11'd257, 1'b0);
		random_burst(40, 0, 2047, 4095, 0);
		load_setting(12'd0, 12'd2048, 12'd4095, 11'd0, 11'd0, 1'b0);
		random_burst(40, 2048, 0, 0, 4095);

		// long hold-off on the result side while samples keep coming
		hold_off_request = 1'b1;
		random_burst(30, 2048, 0, 0, 4095);

		// random calibrations, mostly sane ordering with a curve
		for (int p = 0; p < 12; p++) begin
			r_mid = $urandom_range(0, 4095);
			r_min = (p % 4 == 3) ? $urandom_range(0, 4095) : $urandom_range(0, r_mid);
			r_max = (p % 4 == 3) ? $urandom_range(0, 4095) : $urandom_range(r_mid, 4095);
			r_zone = (p % 3 == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 200);
			r_curve = $urandom_range(0, 3) ? $urandom_range(257, 2047) : $urandom_range(0, 256);
			load_setting(r_min, r_mid, r_max, r_zone, r_curve, $urandom_range(0, 1));
			random_burst(40, r_mid, r_zone, r_min, r_max);
		end

		s_tvalid <= 1'b0;
		while (pending_words != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d samples over %0d register settings, %0d result words checked",
			samples_sent, phases_run + 1, words_checked);
		$display("dead zone edges, empty spans, curve exponents and a long output stall covered");
		if (fail_count == 0 && pending_words == 0) begin
			$display("joystick_axis_conditioner_tb OK");
		end else begin
			$display("%0d mismatches, %0d words missing", fail_count, pending_words);
			$display("joystick_axis_conditioner_tb NOT OK");
		end
		$finish;
	end
endmodule
